// ===== hw/rtl/ppc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ppc_pkg
// shared types, status codes and sizes of the pwm reload/compare calculator
// ---------------------------------------------------------------------------
package ppc_pkg;

    localparam int CounterWidth = 16;
    localparam int ClkWidth     = 27;
    localparam int DivSteps     = 27;
    localparam logic [26:0] ClockReset = 27'd16000000;
    localparam logic [7:0]  DeadLimit  = 8'd10;
    localparam logic [7:0]  DutyFull   = 8'd100;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_DEAD   = 3'd1,
        ST_FREQ   = 3'd2,
        ST_PERIOD = 3'd3,
        ST_DUTY   = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [26:0] frequency_hz;
        logic [7:0]  duty_percent;
        logic [7:0]  dead_cycles;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  channel_out;
        logic [15:0] reload_value;
        logic [15:0] compare_value;
        logic [3:0]  dead_out;
    } rsp_t;

    // per-item control carried alongside the divider
    typedef struct packed {
        logic [2:0] channel;
        logic [7:0] duty;
        logic [3:0] dead;
        status_t    status;
        logic       need_div;
    } ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pwm_period_compare_calc.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pwm_period_compare_calc
// frequency, duty and dead time to reload and compare for an up-counter
// ---------------------------------------------------------------------------
//  channel   direction  signals
//  req       in         req_valid, req_stall, req (ppc_pkg::req_t)
//  rsp       out        rsp_valid, rsp_stall, rsp (ppc_pkg::rsp_t)
//  config    in         cfg_we, cfg_data (pwm_clock_hz)
//
//  one transaction per cycle unless rsp stalls; the pipe is a 1-stage check, a
//  27-stage restoring divider (one quotient bit per stage), a multiply
//  stage, a divide-by-100 stage and an output stage.
//  the divider depth sets the latency. reset clears valid bits and loads
//  the clock register with 16 MHz. a stall on a valid rsp freezes the whole pipe.
module pwm_period_compare_calc (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [26:0]    cfg_data,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ppc_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ppc_pkg::rsp_t       rsp
);

    localparam int N = ppc_pkg::DivSteps;

    logic [26:0] clock_reg;
    logic        adv;

    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_reg <= ppc_pkg::ClockReset;
        else if (cfg_we)
            clock_reg <= cfg_data;
    end

    // stage 0: checks
    ppc_pkg::ctl_t ctl0_next;
    always_comb
    begin
        ctl0_next.channel  = req.channel;
        ctl0_next.duty     = req.duty_percent;
        ctl0_next.dead     = req.dead_cycles[3:0];
        ctl0_next.need_div = 1'b0;
        ctl0_next.status   = ppc_pkg::ST_OK;
        if (req.dead_cycles > ppc_pkg::DeadLimit)
            ctl0_next.status = ppc_pkg::ST_DEAD;
        else if (req.duty_percent == 8'd0 || req.duty_percent == ppc_pkg::DutyFull)
            ctl0_next.need_div = 1'b0;
        else if (req.duty_percent > ppc_pkg::DutyFull)
            ctl0_next.status = ppc_pkg::ST_DUTY;
        else if (req.frequency_hz == 27'd0)
            ctl0_next.status = ppc_pkg::ST_FREQ;
        else
            ctl0_next.need_div = 1'b1;
    end

    // divider pipeline: stage k holds remainder, quotient, divisor, dividend
    logic          v_reg   [0:N];
    ppc_pkg::ctl_t c_reg   [0:N];
    logic [27:0]   rem_reg [0:N];
    logic [26:0]   q_reg   [0:N];
    logic [26:0]   d_reg   [0:N];
    logic [26:0]   n_reg   [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= req_valid;
            for (int k = 1; k <= N; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg[0]   <= ctl0_next;
            rem_reg[0] <= 28'd0;
            q_reg[0]   <= 27'd0;
            d_reg[0]   <= req.frequency_hz;
            n_reg[0]   <= clock_reg;
        end
    end

    for (genvar g = 1; g <= N; g++)
    begin : g_div
        logic [27:0] sh;
        logic [28:0] diff;
        assign sh   = {rem_reg[g-1][26:0], n_reg[g-1][N-g]};
        assign diff = {1'b0, sh} - {2'b00, d_reg[g-1]};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_reg[g] <= c_reg[g-1];
                d_reg[g] <= d_reg[g-1];
                n_reg[g] <= n_reg[g-1];
                if (!diff[28])
                begin
                    rem_reg[g] <= diff[27:0];
                    q_reg[g]   <= {q_reg[g-1][25:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= sh;
                    q_reg[g]   <= {q_reg[g-1][25:0], 1'b0};
                end
            end
        end
    end

    // multiply stage: period range check and period*duty
    logic          vm_reg;
    ppc_pkg::ctl_t cm_reg;
    logic [16:0]   per_reg;
    logic [23:0]   prod_reg;
    ppc_pkg::ctl_t cm_next;
    logic [26:0]   per;

    assign per = q_reg[N];
    always_comb
    begin
        cm_next = c_reg[N];
        if (c_reg[N].need_div && (per == 27'd0 || per > 27'd65536))
            cm_next.status = ppc_pkg::ST_PERIOD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (adv)
            vm_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cm_reg   <= cm_next;
            per_reg  <= per[16:0];
            prod_reg <= 24'(per[16:0]) * 24'(c_reg[N].duty[6:0]);
        end
    end

    // divide by 100 via reciprocal: floor(x*41943 >> 22) with one correction
    logic          vq_reg;
    ppc_pkg::ctl_t cq_reg;
    logic [16:0]   perq_reg;
    logic [23:0]   prodq_reg;
    logic [40:0]   recip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= 1'b0;
        else if (adv)
            vq_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cq_reg    <= cm_reg;
            perq_reg  <= per_reg;
            prodq_reg <= prod_reg;
            recip_reg <= 41'(prod_reg) * 41'd41943;
        end
    end

    logic [23:0] on_est;
    logic [23:0] on_fix;
    logic [30:0] back;
    logic [15:0] on16;
    logic [15:0] cmp_base;
    ppc_pkg::rsp_t rsp_next;

    always_comb
    begin
        on_est = 24'(recip_reg[40:22]);
        back   = 31'(on_est) * 31'd100;
        on_fix = ((31'(prodq_reg) - back) >= 31'd100) ? on_est + 24'd1 : on_est;
        on16   = (on_fix == 24'd0) ? 16'd1 : on_fix[15:0];
        rsp_next.status        = cq_reg.status;
        rsp_next.channel_out   = cq_reg.channel;
        rsp_next.reload_value  = 16'd0;
        rsp_next.compare_value = 16'd0;
        rsp_next.dead_out      = 4'd0;
        cmp_base = 16'd0;
        if (cq_reg.status == ppc_pkg::ST_OK)
        begin
            if (cq_reg.duty == 8'd0)
            begin
                rsp_next.reload_value = 16'hFFFF;
                cmp_base = 16'd0;
            end
            else if (cq_reg.duty == ppc_pkg::DutyFull)
            begin
                rsp_next.reload_value = 16'hFFFF;
                cmp_base = 16'hFFFF;
            end
            else
            begin
                rsp_next.reload_value = 16'(17'h10000 - perq_reg);
                cmp_base = 16'hFFFF - on16;
            end
            rsp_next.compare_value = cmp_base + 16'(cq_reg.dead);
            rsp_next.dead_out      = cq_reg.dead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid <= 1'b0;
        else if (adv)
            rsp_valid <= vq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp <= rsp_next;
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ppc_pkg::ST_OK |->
        rsp.reload_value == 16'd0 && rsp.compare_value == 16'd0)
        else $error("error result carries values");
    a_dead_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.dead_out <= 4'd10)
        else $error("dead time out of range");

endmodule
`default_nettype wire
